// ----- src/ptpr_pkg.sv -----
// ----------------------------------------------------------------------------
// ptpr_pkg
// Shared types, constants and CRC helpers of the point-to-point frame receiver.
// ----------------------------------------------------------------------------
package ptpr_pkg;

  localparam int MTU        = 512;
  localparam int LEN_MAX    = MTU - 8;
  localparam int BL_W       = $clog2(LEN_MAX + 1);
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [7:0]  DLE_BYTE   = 8'h10;
  localparam logic [7:0]  ESC_MASK   = 8'h7f;
  localparam logic [7:0]  PRE_FIRST  = 8'h55;
  localparam logic [7:0]  PRE_SECOND = 8'hff;
  localparam logic [7:0]  CRC8_INIT  = 8'hff;
  localparam logic [7:0]  CRC8_POLY  = 8'h81;
  localparam logic [15:0] CRC16_INIT = 16'hffff;
  localparam logic [15:0] CRC16_POLY = 16'h8408;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_PRE1 = 4'd1,
    PH_HDR0 = 4'd2,
    PH_HDR1 = 4'd3,
    PH_HDR2 = 4'd4,
    PH_HDR3 = 4'd5,
    PH_DATA = 4'd6,
    PH_CRCL = 4'd7,
    PH_CRCH = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    K_PAYLOAD  = 2'd0,
    K_GOOD     = 2'd1,
    K_CRC_ERR  = 2'd2,
    K_TOO_LONG = 2'd3
  } kind_t;

  typedef struct packed {
    logic       abort;
    logic [7:0] data;
  } qitem_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- src/ptpr_front.sv -----
// ----------------------------------------------------------------------------
// ptpr_front
// Input side: removes DLE escapes and queues destuffed bytes and abort marks.
// ----------------------------------------------------------------------------
module ptpr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_byte,
  input  logic            in_abort,
  input  logic            q_full,
  output logic            push_valid,
  output ptpr_pkg::qitem_t push_item
);
  import ptpr_pkg::*;

  logic esc_r;
  logic esc_nxt;
  logic acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    esc_nxt = esc_r;
    if (acc) begin
      if (in_abort) begin
        esc_nxt = 1'b0;
      end else if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (in_rx_byte == DLE_BYTE) begin
        esc_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else begin
      esc_r <= esc_nxt;
    end
  end

  assign push_valid      = acc && (in_abort || esc_r || (in_rx_byte != DLE_BYTE));
  assign push_item.abort = in_abort;
  assign push_item.data  = esc_r ? (in_rx_byte & ESC_MASK) : in_rx_byte;

endmodule

// ----- src/ptpr_queue.sv -----
// ----------------------------------------------------------------------------
// ptpr_queue
// Short queue between the destuffing front and the framing back end.
// ----------------------------------------------------------------------------
module ptpr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  ptpr_pkg::qitem_t push_item,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop,
  output ptpr_pkg::qitem_t pop_item
);
  import ptpr_pkg::*;

  qitem_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- src/ptpr_back.sv -----
// ----------------------------------------------------------------------------
// ptpr_back
// Framing back end: preamble hunt, header check and replay, payload and CRC-16.
// ----------------------------------------------------------------------------
module ptpr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  ptpr_pkg::qitem_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_frame_type,
  output logic [8:0]       out_payload_len,
  output logic             out_last
);
  import ptpr_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [BL_W-1:0]   bl_r, bl_nxt, bl_dec;
  logic [15:0]       dcrc_r, dcrc_nxt;
  logic [7:0]        crcl_r, crcl_nxt;
  logic [7:0]        hcrc_r, hcrc_nxt;
  logic              rep_r, rep_nxt;
  logic [1:0]        rep_idx_r, rep_idx_nxt;
  logic [7:0]        store_r [4];

  logic              ready;
  logic              live;
  logic              step;
  logic [7:0]        b;
  logic [15:0]       hdr_len;
  logic              hdr_ok;
  logic              st_we;
  logic [1:0]        st_idx;

  logic              res_valid;
  kind_t             res_kind;
  logic [7:0]        res_data;
  logic              res_last;

  logic              ov_r;
  logic [1:0]        okind_r;
  logic [7:0]        odata_r;
  logic [7:0]        otype_r;
  logic [8:0]        olen_r;
  logic              olast_r;

  assign ready   = !rep_r && (!ov_r || out_ready);
  assign q_pop   = ready && q_valid;
  assign live    = q_pop && !q_item.abort;
  assign step    = live || rep_r;
  assign b       = rep_r ? store_r[rep_idx_r] : q_item.data;
  assign hdr_len = {store_r[1], store_r[2]};
  assign hdr_ok  = (b == ~hcrc_r);
  assign bl_dec  = (bl_r != '0) ? (bl_r - 1'b1) : bl_r;
  assign st_idx  = 2'(phase_r - PH_HDR0);
  assign st_we   = step && (phase_r == PH_HDR0 || phase_r == PH_HDR1 ||
                            phase_r == PH_HDR2 || phase_r == PH_HDR3);

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    bl_nxt      = bl_r;
    dcrc_nxt    = dcrc_r;
    crcl_nxt    = crcl_r;
    hcrc_nxt    = hcrc_r;
    rep_nxt     = rep_r;
    rep_idx_nxt = rep_idx_r;
    if (q_pop && q_item.abort) begin
      phase_nxt = PH_HUNT;
      bl_nxt    = '0;
      dcrc_nxt  = CRC16_INIT;
      crcl_nxt  = '0;
    end else if (step) begin
      if (rep_r) begin
        rep_idx_nxt = rep_idx_r + 1'b1;
        rep_nxt     = (rep_idx_r != 2'd3);
      end
      case (phase_r)
        PH_DATA: begin
          dcrc_nxt = crc16_byte(dcrc_r, b);
          bl_nxt   = bl_dec;
          if (bl_dec == '0) begin
            phase_nxt = PH_CRCL;
          end
        end
        PH_CRCL: begin
          crcl_nxt  = b;
          phase_nxt = PH_CRCH;
        end
        PH_CRCH: begin
          phase_nxt = PH_HUNT;
        end
        PH_PRE1: begin
          phase_nxt = (b == PRE_SECOND) ? PH_HDR0 : PH_HUNT;
        end
        PH_HDR0: begin
          hcrc_nxt  = crc8_byte(CRC8_INIT, b);
          phase_nxt = PH_HDR1;
        end
        PH_HDR1, PH_HDR2: begin
          hcrc_nxt  = crc8_byte(hcrc_r, b);
          phase_nxt = phase_t'(phase_r + 4'd1);
        end
        PH_HDR3: begin
          phase_nxt = PH_HUNT;
          if (!hdr_ok) begin
            rep_nxt     = 1'b1;
            rep_idx_nxt = '0;
          end else if (hdr_len != '0 && hdr_len <= 16'(LEN_MAX)) begin
            bl_nxt    = hdr_len[BL_W-1:0];
            dcrc_nxt  = CRC16_INIT;
            phase_nxt = PH_DATA;
          end
        end
        default: begin
          phase_nxt = (b == PRE_FIRST) ? PH_PRE1 : PH_HUNT;
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res_kind  = K_PAYLOAD;
    res_data  = '0;
    res_last  = 1'b0;
    if (live) begin
      case (phase_r)
        PH_DATA: begin
          res_valid = 1'b1;
          res_data  = b;
        end
        PH_CRCH: begin
          res_valid = 1'b1;
          res_last  = 1'b1;
          res_kind  = ({b, crcl_r} == ~dcrc_r) ? K_GOOD : K_CRC_ERR;
        end
        PH_HDR3: begin
          if (hdr_ok && hdr_len == '0) begin
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_kind  = K_GOOD;
          end else if (hdr_ok && hdr_len > 16'(LEN_MAX)) begin
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_kind  = K_TOO_LONG;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_r[st_idx] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      bl_r      <= '0;
      dcrc_r    <= CRC16_INIT;
      crcl_r    <= '0;
      hcrc_r    <= CRC8_INIT;
      rep_r     <= 1'b0;
      rep_idx_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      bl_r      <= bl_nxt;
      dcrc_r    <= dcrc_nxt;
      crcl_r    <= crcl_nxt;
      hcrc_r    <= hcrc_nxt;
      rep_r     <= rep_nxt;
      rep_idx_r <= rep_idx_nxt;
      if (res_valid) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      okind_r <= res_kind;
      odata_r <= res_data;
      otype_r <= store_r[0];
      olen_r  <= hdr_len[8:0];
      olast_r <= res_last;
    end
  end

  assign out_valid       = ov_r;
  assign out_kind        = okind_r;
  assign out_data_byte   = odata_r;
  assign out_frame_type  = otype_r;
  assign out_payload_len = olen_r;
  assign out_last        = olast_r;

  a_rep_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r |-> !q_pop)
    else $error("queue popped during header replay");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (bl_r != '0))
    else $error("payload phase with no bytes left");

  a_rep_phase: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r |-> (phase_r != PH_DATA && phase_r != PH_CRCL &&
               phase_r != PH_CRCH && phase_r != PH_HDR3))
    else $error("replay reached a framing phase");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (olast_r == (okind_r != K_PAYLOAD)))
    else $error("last flag disagrees with result kind");

endmodule

// ----- src/ptp_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// ptp_frame_receiver_core
// Point-to-point link frame receiver: destuffing, preamble and header check,
// payload delivery and trailing CRC-16 verdict.
//
//   channel | direction | ports
//   in      | sink      | in_valid, in_ready, in_rx_byte, in_abort
//   out     | source    | out_valid, out_ready, out_kind, out_data_byte,
//           |           | out_frame_type, out_payload_len, out_last
//
// One byte per cycle while in_ready is high; the framer takes one queued
// byte per cycle unless replaying or held by out_ready. A header CRC failure
// replays the four header bytes; in_ready drops if the 2-entry queue fills.
// Results sit in one output register; a stalled out_ready halts the framer.
// Synchronous reset; no clearing pass, the block takes bytes right after it.
// ----------------------------------------------------------------------------
module ptp_frame_receiver_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_abort,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_frame_type,
  output logic [8:0] out_payload_len,
  output logic       out_last
);
  import ptpr_pkg::*;

  logic   push_valid;
  qitem_t push_item;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  qitem_t q_item;

  ptpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .in_abort   (in_abort),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  ptpr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  ptpr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_frame_type  (out_frame_type),
    .out_payload_len (out_payload_len),
    .out_last        (out_last)
  );

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ptp_frame_receiver_core. A queue of raw line beats
// (directed cases first, then random frames, noise, truncated frames and
// aborts) feeds a valid/ready driver. Each accepted beat runs through a
// behavioral decoder that predicts the result beats; a monitor compares
// every accepted result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import ptpr_pkg::*;

  typedef struct packed {
    logic       abort;
    logic [7:0] rx;
  } line_beat_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] ftype;
    logic [8:0] plen;
    logic       last;
  } rx_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_abort = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic [7:0] out_frame_type;
  logic [8:0] out_payload_len;
  logic       out_last;

  line_beat_t line_beats [$];
  rx_result_t want_results [$];
  int         errors = 0;
  int         cyc = 0;
  logic       calm;

  phase_t      ph;
  logic        esc_p;
  logic [7:0]  hdr [4];
  logic [9:0]  left;
  logic [15:0] dcrc;
  logic [7:0]  crc_lo;

  ptp_frame_receiver_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .in_abort       (in_abort),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_frame_type (out_frame_type),
    .out_payload_len(out_payload_len),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) cyc <= cyc + 1;
  assign calm = (cyc >= 400) && (cyc < 800);

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ CRC8_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ CRC16_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic void rx_reset_state();
    ph = PH_HUNT;
    esc_p = 1'b0;
    for (int i = 0; i < 4; i++) hdr[i] = 8'h00;
    left = '0;
    dcrc = CRC16_INIT;
    crc_lo = 8'h00;
  endfunction

  function automatic void post(input kind_t k, input logic [7:0] d, input logic l);
    rx_result_t r;
    r.kind = k;
    r.data = d;
    r.ftype = hdr[0];
    r.plen = {hdr[1][0], hdr[2]};
    r.last = l;
    want_results.push_back(r);
  endfunction

  function automatic logic hunt_step(input logic [7:0] b);
    logic [3:0] idx;
    hunt_step = 1'b0;
    case (ph)
      PH_PRE1: ph = (b == PRE_SECOND) ? PH_HDR0 : PH_HUNT;
      PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
        idx = ph - PH_HDR0;
        hdr[idx[1:0]] = b;
        if (ph == PH_HDR3) hunt_step = 1'b1;
        else ph = phase_t'(ph + 4'd1);
      end
      default: ph = (b == PRE_FIRST) ? PH_PRE1 : PH_HUNT;
    endcase
  endfunction

  function automatic void rx_decode(input logic [7:0] raw, input logic abrt);
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  again [4];
    logic [15:0] len;
    b = raw;
    if (abrt) begin
      rx_reset_state();
      return;
    end
    if (esc_p) begin
      b = b & ESC_MASK;
      esc_p = 1'b0;
    end else if (b == DLE_BYTE) begin
      esc_p = 1'b1;
      return;
    end
    case (ph)
      PH_DATA: begin
        dcrc = crc16_next(dcrc, b);
        if (left != 0) left = left - 10'd1;
        if (left == 0) ph = PH_CRCL;
        post(K_PAYLOAD, b, 1'b0);
      end
      PH_CRCL: begin
        crc_lo = b;
        ph = PH_CRCH;
      end
      PH_CRCH: begin
        ph = PH_HUNT;
        post(({b, crc_lo} == ~dcrc) ? K_GOOD : K_CRC_ERR, 8'h00, 1'b1);
      end
      default: begin
        if (hunt_step(b)) begin
          c = CRC8_INIT;
          for (int i = 0; i < 3; i++) c = crc8_next(c, hdr[i]);
          if (hdr[3] != ~c) begin
            again = hdr;
            ph = PH_HUNT;
            for (int i = 0; i < 4; i++) void'(hunt_step(again[i]));
          end else begin
            len = {hdr[1], hdr[2]};
            ph = PH_HUNT;
            if (len == 0) post(K_GOOD, 8'h00, 1'b1);
            else if (len > LEN_MAX) post(K_TOO_LONG, 8'h00, 1'b1);
            else begin
              left = len[9:0];
              dcrc = CRC16_INIT;
              ph = PH_DATA;
            end
          end
        end
      end
    endcase
  endfunction

  task automatic push_item(input logic [7:0] b, input logic abrt);
    line_beat_t it;
    it.rx = b;
    it.abort = abrt;
    line_beats.push_back(it);
  endtask

  task automatic send_byte(input logic [7:0] v);
    if (v == DLE_BYTE || (!v[7] && $urandom_range(0, 9) == 0)) begin
      push_item(DLE_BYTE, 1'b0);
      push_item({1'($urandom), v[6:0]}, 1'b0);
    end else begin
      push_item(v, 1'b0);
    end
  endtask

  // keep < 0 sends the whole frame, otherwise only the first keep bytes
  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
                            input bit hdr_bad, input bit data_bad, input int keep);
    logic [7:0]  fb [$];
    logic [7:0]  c;
    logic [15:0] d;
    logic [7:0]  v;
    fb = {PRE_FIRST, PRE_SECOND, ftype, len[15:8], len[7:0]};
    c = crc8_next(crc8_next(crc8_next(CRC8_INIT, ftype), len[15:8]), len[7:0]);
    c = ~c;
    if (hdr_bad) c = c ^ (8'h01 << $urandom_range(0, 7));
    fb.push_back(c);
    if (!hdr_bad && len != 0 && len <= LEN_MAX) begin
      d = CRC16_INIT;
      for (int i = 0; i < len; i++) begin
        v = 8'($urandom);
        d = crc16_next(d, v);
        fb.push_back(v);
      end
      d = ~d;
      if (data_bad) d = d ^ (16'h0001 << $urandom_range(0, 15));
      fb.push_back(d[7:0]);
      fb.push_back(d[15:8]);
    end
    foreach (fb[i]) begin
      if (keep < 0 || i < keep) send_byte(fb[i]);
    end
  endtask

  task automatic note_fail(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // driver: hold valid and payload until the beat is taken
  always @(posedge clk) begin : drive
    line_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) rx_decode(in_rx_byte, in_abort);
      if (!in_valid || in_ready) begin
        if (line_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
          nxt = line_beats.pop_front();
          in_valid <= 1'b1;
          in_rx_byte <= nxt.rx;
          in_abort <= nxt.abort;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin : monitor
    rx_result_t w;
    if (rst_n && out_valid && out_ready) begin
      if (want_results.size() == 0) begin
        note_fail($sformatf("unexpected beat: kind=%0d data=%02h type=%02h len=%0d last=%0b",
                            out_kind, out_data_byte, out_frame_type, out_payload_len,
                            out_last));
      end else begin
        w = want_results.pop_front();
        if (out_kind != w.kind || out_data_byte != w.data || out_frame_type != w.ftype ||
            out_payload_len != w.plen || out_last != w.last) begin
          note_fail($sformatf({"mismatch: exp kind=%0d data=%02h type=%02h len=%0d last=%0b",
                               " got kind=%0d data=%02h type=%02h len=%0d last=%0b"},
                              w.kind, w.data, w.ftype, w.plen, w.last,
                              out_kind, out_data_byte, out_frame_type, out_payload_len,
                              out_last));
        end
      end
    end
  end

  initial begin : stimulus
    int target;
    int pick;
    int sel;
    logic [15:0] len;
    rx_reset_state();

    push_item(8'hA5, 1'b1);
    push_item(8'h13, 1'b0);
    push_item(PRE_FIRST, 1'b0);
    push_item(8'h12, 1'b0);
    send_frame(8'hFF, 16'h0000, 1'b0, 1'b0, -1);
    send_frame(DLE_BYTE, 16'hFFFF, 1'b0, 1'b0, -1);
    send_frame(PRE_FIRST, 16'hFF00, 1'b1, 1'b0, -1);
    push_item(8'h00, 1'b1);
    send_frame(8'h00, 16'd1, 1'b0, 1'b0, -1);
    push_item(DLE_BYTE, 1'b0);
    push_item(8'hFF, 1'b1);

    send_frame(8'($urandom), 16'(LEN_MAX), 1'b0, 1'b0, -1);
    target = 700;
    while (line_beats.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        sel = $urandom_range(0, 99);
        if (sel < 6) len = 16'd0;
        else if (sel < 12) len = sel[0] ? 16'(LEN_MAX + 1) : 16'($urandom_range(LEN_MAX + 1, 65535));
        else if (sel < 22) len = 16'($urandom_range(25, 80));
        else len = 16'($urandom_range(1, 24));
        send_frame(8'($urandom), len, $urandom_range(0, 99) < 8,
                   $urandom_range(0, 99) < 15, -1);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) push_item(8'($urandom), 1'b0);
      end else if (pick < 88) begin
        send_frame(8'($urandom), 16'($urandom_range(0, 20)), 1'b0, 1'b0,
                   $urandom_range(1, 12));
        if ($urandom_range(0, 1)) push_item(8'($urandom), 1'b1);
      end else if (pick < 93) begin
        push_item(8'($urandom), 1'b1);
      end else begin
        push_item(PRE_FIRST, 1'b0);
        push_item(8'($urandom), 1'b0);
      end
    end

    while (line_beats.size() != 0 || in_valid) @(posedge clk);
    while (want_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
